// ----- hw/rtl/mfma_pkg.sv -----
// ----------------------------------------------------------------------------
// Minifloat multiply/add package
// Widths, payload structs, stage structs and status codes shared by the
// pipeline stages of the minifloat multiply/add unit.
// ----------------------------------------------------------------------------
package mfma_pkg;

	// Format of one code: biased exponent above a fraction with hidden one.
	localparam int EXP_BITS  = 5;
	localparam int FRAC_BITS = 7;
	localparam int CODE_W    = EXP_BITS + FRAC_BITS;
	localparam int BIAS      = (1 << (EXP_BITS - 1)) - 1;
	localparam int E_MAX     = BIAS - 1;
	localparam int E_MIN     = 1 - BIAS;

	// Significand with the hidden one, and the datapath widths derived from it.
	localparam int SIG_W  = FRAC_BITS + 1;
	localparam int ACC_W  = 2 * SIG_W + 1;
	localparam int EXP_W  = EXP_BITS + 2;
	localparam int SH_W   = $clog2(FRAC_BITS + 2);
	localparam int GAP_MAX = FRAC_BITS + 1;

	// Operation kinds.
	localparam logic KIND_MUL = 1'b0;
	localparam logic KIND_ADD = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef logic signed [EXP_W-1:0] exp_t;
	typedef logic [SIG_W-1:0]        sig_t;

	// Input transaction.
	typedef struct packed {
		logic              kind;
		logic [CODE_W-1:0] operand_a;
		logic [CODE_W-1:0] operand_b;
	} mfma_req_t;

	// Output transaction.
	typedef struct packed {
		logic [CODE_W-1:0] result_code;
		logic [1:0]        status;
	} mfma_rsp_t;

	// Decoded operands after the first stage.
	typedef struct packed {
		logic              is_mul;
		exp_t              exp;
		sig_t              sig_big;
		sig_t              sig_small;
		logic [SH_W-1:0]   sh;
	} mfma_dec_t;

	// Raw product or aligned sum after the second stage.
	typedef struct packed {
		exp_t              exp;
		logic [ACC_W-1:0]  acc;
		logic [SH_W-1:0]   sh;
	} mfma_acc_t;

endpackage

// ----- hw/rtl/minifloat_mul_add_unit.sv -----
// ----------------------------------------------------------------------------
// Minifloat multiply/add unit
// Multiplies or adds two positive 12-bit minifloat codes with truncation
// and reports overflow and underflow of the result exponent.
//
//   channel   | ports                     | transfer
//   ----------+---------------------------+------------------------------
//   operands  | start, busy, request      | start high while busy low
//   result    | done, response            | done high for one cycle
//
// Each transaction passes the registered stages decode, multiply or aligned
// add, then normalise and pack.
// A new transaction may enter on every cycle, so busy is never raised.
// Reset clears only the stage valid bits; payload registers are not reset.
// The receiver cannot stall, so no back-pressure exists in the pipeline.
// ----------------------------------------------------------------------------
module minifloat_mul_add_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mfma_pkg::mfma_req_t request,
	output logic                done,
	output mfma_pkg::mfma_rsp_t response
);
	import mfma_pkg::*;

	logic      valid_s1;
	logic      valid_s2;
	mfma_dec_t dec_s1;
	mfma_acc_t acc_s2;

	// The pipeline takes a transaction on every cycle.
	assign busy = 1'b0;

	// Stage one: decode and ordering.
	mfma_align u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (start && !busy),
		.req      (request),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1)
	);

	// Stage two: product or aligned sum.
	mfma_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.valid_s2 (valid_s2),
		.acc_s2   (acc_s2)
	);

	// Stage three: normalise, range check and pack.
	mfma_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.acc_s2   (acc_s2),
		.valid_s3 (done),
		.rsp_s3   (response)
	);

	// Every result comes from a transaction accepted earlier.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a matching accepted transaction");

	// An out-of-range result carries a zero code.
	a_zero_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(done && response.status != ST_OK) |-> (response.result_code == '0))
		else $error("non-zero code with overflow or underflow status");

	// A valid result never has a zero biased exponent field.
	a_exp_field: assert property (@(posedge clk) disable iff (!arst_n)
		(done && response.status == ST_OK)
			|-> (response.result_code[CODE_W-1:FRAC_BITS] != '0))
		else $error("in-range result packed with a zero exponent field");

endmodule

// ----- hw/rtl/mfma_align.sv -----
// ----------------------------------------------------------------------------
// Minifloat operand decode stage
// Unpacks both codes, orders them by exponent for an add, limits the
// alignment gap and registers the result as pipeline stage one.
// ----------------------------------------------------------------------------
module mfma_align (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	input  mfma_pkg::mfma_req_t req,
	output logic                valid_s1,
	output mfma_pkg::mfma_dec_t dec_s1
);
	import mfma_pkg::*;

	exp_t      ea;
	exp_t      eb;
	exp_t      gap;
	sig_t      ma;
	sig_t      mb;
	logic      a_ge;
	mfma_dec_t dec;

	// Unbiased exponents and significands with the hidden one.
	assign ea = exp_t'({2'b00, req.operand_a[CODE_W-1:FRAC_BITS]}) - exp_t'(BIAS);
	assign eb = exp_t'({2'b00, req.operand_b[CODE_W-1:FRAC_BITS]}) - exp_t'(BIAS);
	assign ma = {1'b1, req.operand_a[FRAC_BITS-1:0]};
	assign mb = {1'b1, req.operand_b[FRAC_BITS-1:0]};
	assign a_ge = (ea >= eb);
	assign gap = a_ge ? (ea - eb) : (eb - ea);

	// A multiply normalises from the fraction width; an add from the gap.
	always_comb begin
		if (req.kind == KIND_MUL) begin
			dec.is_mul    = 1'b1;
			dec.exp       = ea + eb;
			dec.sig_big   = ma;
			dec.sig_small = mb;
			dec.sh        = SH_W'(FRAC_BITS);
		end else begin
			dec.is_mul    = 1'b0;
			dec.exp       = a_ge ? ea : eb;
			dec.sig_big   = a_ge ? ma : mb;
			dec.sig_small = a_ge ? mb : ma;
			if (int'(gap) > GAP_MAX) begin
				dec.sh = SH_W'(GAP_MAX);
			end else begin
				dec.sh = SH_W'(gap);
			end
		end
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		dec_s1 <= dec;
	end

endmodule

// ----- hw/rtl/mfma_core.sv -----
// ----------------------------------------------------------------------------
// Minifloat arithmetic stage
// Forms the exact significand product or the exactly aligned significand
// sum and registers it as pipeline stage two.
// ----------------------------------------------------------------------------
module mfma_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  mfma_pkg::mfma_dec_t dec_s1,
	output logic                valid_s2,
	output mfma_pkg::mfma_acc_t acc_s2
);
	import mfma_pkg::*;

	logic [2*SIG_W-1:0] prod;
	logic [ACC_W-1:0]   sum;
	mfma_acc_t          acc;

	// One narrow multiplier and one shifted add; the operation picks one.
	assign prod = (2*SIG_W)'(dec_s1.sig_big) * (2*SIG_W)'(dec_s1.sig_small);
	assign sum  = (ACC_W'(dec_s1.sig_big) << dec_s1.sh) + ACC_W'(dec_s1.sig_small);

	always_comb begin
		acc.exp = dec_s1.exp;
		acc.sh  = dec_s1.sh;
		acc.acc = dec_s1.is_mul ? ACC_W'(prod) : sum;
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		acc_s2 <= acc;
	end

endmodule

// ----- hw/rtl/mfma_pack.sv -----
// ----------------------------------------------------------------------------
// Minifloat normalise and pack stage
// Shifts the raw result down to the fraction, adjusts the exponent for a
// carry, checks the exponent range and registers the output code.
// ----------------------------------------------------------------------------
module mfma_pack (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s2,
	input  mfma_pkg::mfma_acc_t acc_s2,
	output logic                valid_s3,
	output mfma_pkg::mfma_rsp_t rsp_s3
);
	import mfma_pkg::*;

	logic [ACC_W-1:0]     norm;
	logic                 carry;
	logic [FRAC_BITS-1:0] frac;
	exp_t                 e;
	mfma_rsp_t            rsp;

	// The leading one sits either at the fraction width or one above it.
	assign norm  = acc_s2.acc >> acc_s2.sh;
	assign carry = norm[SIG_W];
	assign frac  = carry ? norm[FRAC_BITS:1] : norm[FRAC_BITS-1:0];
	assign e     = acc_s2.exp + exp_t'(carry);

	// Range check and packing; out-of-range results give a zero code.
	always_comb begin
		if (int'(e) > E_MAX) begin
			rsp.result_code = '0;
			rsp.status      = ST_OVERFLOW;
		end else if (int'(e) < E_MIN) begin
			rsp.result_code = '0;
			rsp.status      = ST_UNDERFLOW;
		end else begin
			rsp.result_code = {EXP_BITS'(int'(e) + BIAS), frac};
			rsp.status      = ST_OK;
		end
	end

	// Output valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		rsp_s3 <= rsp;
	end

	// The raw result must always be normalised to within one bit.
	a_leading_one: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (norm[SIG_W] || norm[FRAC_BITS]))
		else $error("raw result has no leading one at the expected place");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minifloat multiply/add unit testbench
// Drives operand transactions into the unit and checks each response against
// a behavioural predictor of the truncating multiply and the exactly aligned
// add. Directed extremes and exponent boundaries are followed by shaped
// random traffic with idle bursts, and finally by a back-to-back stream.
// ----------------------------------------------------------------------------
module tb_top;

	import mfma_pkg::*;

	typedef logic [CODE_W-1:0] code_t;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int EXP_FIELD_MAX  = (1 << EXP_BITS) - 1;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	mfma_req_t request;
	logic      done;
	mfma_rsp_t response;

	// Responses still owed by the unit, oldest first.
	mfma_rsp_t owed_results[$];

	int err_count = 0;
	int n_mul     = 0;
	int n_add     = 0;
	int n_ok      = 0;
	int n_ovf     = 0;
	int n_unf     = 0;

	minifloat_mul_add_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.response (response)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected response for one operand pair: unbiased exponents, significands
	// with the hidden one, then a single normalisation and a truncated fraction.
	function automatic mfma_rsp_t minifloat_result(mfma_req_t req);
		int                   ea;
		int                   eb;
		int                   ebig;
		int                   e;
		int                   gap;
		int                   msb;
		logic [SIG_W-1:0]     ma;
		logic [SIG_W-1:0]     mb;
		logic [SIG_W-1:0]     mbig;
		logic [SIG_W-1:0]     msmall;
		logic [2*SIG_W-1:0]   prod;
		logic [2*SIG_W:0]     sum;
		logic [2*SIG_W:0]     shifted;
		logic [FRAC_BITS-1:0] frac;
		logic [EXP_BITS-1:0]  efield;
		mfma_rsp_t            rsp;
		ea = int'(req.operand_a[CODE_W-1:FRAC_BITS]) - BIAS;
		eb = int'(req.operand_b[CODE_W-1:FRAC_BITS]) - BIAS;
		ma = {1'b1, req.operand_a[FRAC_BITS-1:0]};
		mb = {1'b1, req.operand_b[FRAC_BITS-1:0]};
		if (req.kind == KIND_MUL) begin
			prod = (2*SIG_W)'(ma) * (2*SIG_W)'(mb);
			e = ea + eb;
			// A product of two significands carries into the top bit at most once.
			if (prod[2*SIG_W-1]) begin
				e = e + 1;
				shifted = (2*SIG_W+1)'(prod >> (FRAC_BITS + 1));
			end else begin
				shifted = (2*SIG_W+1)'(prod >> FRAC_BITS);
			end
			frac = shifted[FRAC_BITS-1:0];
		end else begin
			if (ea >= eb) begin
				mbig = ma; msmall = mb; ebig = ea; gap = ea - eb;
			end else begin
				mbig = mb; msmall = ma; ebig = eb; gap = eb - ea;
			end
			// Beyond this gap the smaller operand cannot reach the kept bits.
			if (gap > GAP_MAX)
				gap = GAP_MAX;
			sum = (2*SIG_W+1)'(mbig);
			sum = (sum << gap) + (2*SIG_W+1)'(msmall);
			msb = 0;
			for (int i = 0; i <= 2 * SIG_W; i++)
				if (sum[i])
					msb = i;
			e = ebig - gap + (msb - FRAC_BITS);
			shifted = sum >> (msb - FRAC_BITS);
			frac = shifted[FRAC_BITS-1:0];
		end
		rsp.result_code = '0;
		if (e > E_MAX) begin
			rsp.status = ST_OVERFLOW;
		end else if (e < E_MIN) begin
			rsp.status = ST_UNDERFLOW;
		end else begin
			efield = EXP_BITS'(e + BIAS);
			rsp.result_code = {efield, frac};
			rsp.status = ST_OK;
		end
		return rsp;
	endfunction

	function automatic code_t make_code(int efield, logic [FRAC_BITS-1:0] frac);
		return {efield[EXP_BITS-1:0], frac};
	endfunction

	function automatic int clamp_field(int v);
		if (v < 0)
			return 0;
		if (v > EXP_FIELD_MAX)
			return EXP_FIELD_MAX;
		return v;
	endfunction

	// Record each accepted transaction and check each response on the same edge.
	always @(posedge clk) begin
		mfma_rsp_t want;
		if (arst_n) begin
			if (start && !busy) begin
				owed_results.push_back(minifloat_result(request));
				if (request.kind == KIND_MUL)
					n_mul++;
				else
					n_add++;
			end
			if (done) begin
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected response code %h status %0d", $time,
						response.result_code, response.status);
					err_count++;
				end else begin
					want = owed_results.pop_front();
					if (response.result_code !== want.result_code) begin
						$display("%0t: result_code mismatch, expected %h actual %h", $time,
							want.result_code, response.result_code);
						err_count++;
					end
					if (response.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d actual %0d", $time,
							want.status, response.status);
						err_count++;
					end
					case (want.status)
						ST_OK:       n_ok++;
						ST_OVERFLOW: n_ovf++;
						default:     n_unf++;
					endcase
				end
			end
		end
	end

	// Ends the run if nothing moves on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog expired with %0d responses outstanding", $time,
			owed_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Sends one transaction, optionally after an idle burst; called at a falling edge.
	task automatic send_op(logic kind, code_t a, code_t b, int idle_pct);
		if ($urandom_range(1, 100) <= idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		start = 1'b1;
		request.kind = kind;
		request.operand_a = a;
		request.operand_b = b;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// Holds the sender off until every owed response has arrived.
	task automatic wait_drained();
		start = 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
	endtask

	// Field extremes, exponent zero, the overflow and underflow edges and wide gaps.
	task automatic test_directed();
		send_op(KIND_MUL, 12'h000, 12'h000, 0);
		send_op(KIND_MUL, 12'hFFF, 12'hFFF, 0);
		send_op(KIND_MUL, 12'h780, 12'h780, 0);
		send_op(KIND_MUL, 12'h7FF, 12'h7FF, 0);
		send_op(KIND_MUL, 12'h000, 12'hFFF, 0);
		send_op(KIND_MUL, 12'h07F, 12'hF80, 0);
		send_op(KIND_MUL, 12'hE80, 12'h780, 0);
		send_op(KIND_MUL, 12'hEFF, 12'h7FF, 0);
		send_op(KIND_MUL, 12'h080, 12'h780, 0);
		send_op(KIND_MUL, 12'h080, 12'h700, 0);
		send_op(KIND_MUL, 12'h0FF, 12'h77F, 0);
		send_op(KIND_ADD, 12'h000, 12'h000, 0);
		send_op(KIND_ADD, 12'hFFF, 12'hFFF, 0);
		send_op(KIND_ADD, 12'hFFF, 12'h000, 0);
		send_op(KIND_ADD, 12'h780, 12'h000, 0);
		send_op(KIND_ADD, 12'h000, 12'h7FF, 0);
		send_op(KIND_ADD, 12'h7FF, 12'h3FF, 0);
		send_op(KIND_ADD, 12'h7FF, 12'h37F, 0);
		send_op(KIND_ADD, 12'h7FF, 12'h2FF, 0);
		send_op(KIND_ADD, 12'hEFF, 12'hEFF, 0);
		send_op(KIND_ADD, 12'h780, 12'h780, 0);
		send_op(KIND_ADD, 12'h07F, 12'hF80, 0);
		wait_drained();
	endtask

	// Exponent sums and sums with carries placed right at the range limits.
	task automatic test_exponent_edges(int n_items);
		int    t;
		int    fa;
		int    fb;
		int    lo;
		int    hi;
		code_t a;
		code_t b;
		for (int i = 0; i < n_items; i++) begin
			if (i % 2 == 0) begin
				case ($urandom_range(0, 6))
					0:       t = 13;
					1:       t = 14;
					2:       t = 15;
					3:       t = -13;
					4:       t = -14;
					5:       t = -15;
					default: t = -16;
				endcase
				lo = (t - 1 > 0) ? t - 1 : 0;
				hi = (30 + t < EXP_FIELD_MAX) ? 30 + t : EXP_FIELD_MAX;
				fa = $urandom_range(lo, hi);
				fb = 30 + t - fa;
				send_op(KIND_MUL, make_code(fa, FRAC_BITS'($urandom)),
					make_code(fb, FRAC_BITS'($urandom)), 20);
			end else begin
				case ($urandom_range(0, 4))
					0:       fa = 0;
					1:       fa = 1;
					2:       fa = 28;
					3:       fa = 29;
					default: fa = EXP_FIELD_MAX;
				endcase
				fb = clamp_field(fa - $urandom_range(0, 10));
				a = make_code(fa, FRAC_BITS'($urandom));
				b = make_code(fb, FRAC_BITS'($urandom));
				if ($urandom_range(0, 1))
					send_op(KIND_ADD, a, b, 20);
				else
					send_op(KIND_ADD, b, a, 20);
			end
		end
		wait_drained();
	endtask

	// Mostly in-range operand pairs with random fractions, some raw noise,
	// and idle density that changes every hundred transactions.
	task automatic test_random_mix(int n_items);
		int    fa;
		int    fb;
		int    idle_pct;
		logic  kind;
		code_t a;
		code_t b;
		idle_pct = 0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 100 == 0)
				idle_pct = $urandom_range(0, 2) * 20;
			if (i % 250 == 249)
				wait_drained();
			kind = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0) begin
				a = code_t'($urandom);
				b = code_t'($urandom);
			end else begin
				fa = $urandom_range(0, EXP_FIELD_MAX);
				if (kind == KIND_MUL)
					fb = clamp_field(30 + $urandom_range(0, 32) - 16 - fa);
				else
					fb = clamp_field(fa + $urandom_range(0, 20) - 10);
				a = make_code(fa, FRAC_BITS'($urandom));
				b = make_code(fb, FRAC_BITS'($urandom));
			end
			send_op(kind, a, b, idle_pct);
		end
		wait_drained();
	endtask

	// Back-to-back transactions with no idle cycles at all.
	task automatic test_stream(int n_items);
		for (int i = 0; i < n_items; i++)
			send_op(1'($urandom_range(0, 1)), code_t'($urandom), code_t'($urandom), 0);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_exponent_edges(300);
		test_random_mix(1100);
		test_stream(300);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (owed_results.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, owed_results.size());
			err_count++;
		end
		$display("Run covered %0d multiplies and %0d adds: %0d in range, %0d overflow, %0d underflow.",
			n_mul, n_add, n_ok, n_ovf, n_unf);
		$display("Stimulus: field extremes, exponent limits, shaped random with idle bursts, stream.");
		if (err_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
